// ----- hdl/erfc_erf_approximation_core_assert.svh -----
// Assertion macros shared by erfc_div_cell and the top-level core.
`ifndef ERFC_ERF_APPROXIMATION_CORE_ASSERT_SVH
`define ERFC_ERF_APPROXIMATION_CORE_ASSERT_SVH

// Check a property outside reset.
`define ERFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ERFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/erfc_pkg.sv -----
`timescale 1ns / 1ps
package erfc_pkg;

  localparam int IN_FRAC_BITS_DEF  = 12;
  localparam int OUT_FRAC_BITS_DEF = 24;

  localparam int XW           = 16;
  localparam int OW           = 25;
  localparam int QW           = 31;
  localparam int SW           = 33;
  localparam int PW           = 32;
  localparam int EW           = 33;
  localparam int UW           = 32;
  localparam int NW           = 7;
  localparam int FW           = 28;
  localparam int Y28W         = 34;
  localparam int DIV_STEPS    = 31;
  localparam int TAYLOR_TERMS = 12;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000;
  localparam logic [63:0] DEC_HALF  = 64'd500000000;

  localparam logic [63:0] A1_Q30 = (64'd254829592 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A2_Q30 = (64'd284496736 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A3_Q30 = (64'd1421413741 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A4_Q30 = (64'd1453152027 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A5_Q30 = (64'd1061405429 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] PX_Q30 = (64'd327591100 * (64'd1 << 30) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] L2E_Q28 = (64'd1442695041 * (64'd1 << 28) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] LN2_Q32_W = (64'd693147181 * (64'd1 << 32) + DEC_HALF) / DEC_SCALE;

  localparam logic signed [SW-1:0] C_A1 = SW'(A1_Q30);
  localparam logic signed [SW-1:0] C_A2 = SW'(-A2_Q30);
  localparam logic signed [SW-1:0] C_A3 = SW'(A3_Q30);
  localparam logic signed [SW-1:0] C_A4 = SW'(-A4_Q30);
  localparam logic signed [SW-1:0] C_A5 = SW'(A5_Q30);
  localparam logic signed [SW-1:0] C_ZERO = '0;

  localparam logic [28:0] P_Q30     = 29'(PX_Q30);
  localparam logic [28:0] LOG2E_Q28 = 29'(L2E_Q28);
  localparam logic [31:0] LN2_Q32   = 32'(LN2_Q32_W);

  typedef struct packed {
    logic          vld;
    logic          flush;
    logic [NW-1:0] n;
  } exp_ctl_t;

endpackage

// ----- hdl/erfc_div_cell.sv -----
`timescale 1ns / 1ps
`include "erfc_erf_approximation_core_assert.svh"
module erfc_div_cell
  import erfc_pkg::*;
#(
  parameter int DEN_W = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [30:0]      low_i,
  input  logic [QW-1:0]    quo_i,
  output logic             vld_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [30:0]      low_o,
  output logic [QW-1:0]    quo_o
);

  logic             vld_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [30:0]      low_r, low_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial   = {rem_i, low_i[30]};
    diff    = trial - {1'b0, den_i};
    ge      = trial >= {1'b0, den_i};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    low_nxt = {low_i[29:0], 1'b0};
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_i;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign low_o = low_r;
  assign quo_o = quo_r;

  `ERFC_ASSERT(a_rem_below_den, vld_r && $past(vld_i) |-> rem_r < den_r, "remainder not below divisor")

endmodule

// ----- hdl/erfc_hrn_cell.sv -----
`timescale 1ns / 1ps
module erfc_hrn_cell
  import erfc_pkg::*;
#(
  parameter logic signed [SW-1:0] COEF = C_ZERO
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic signed [SW-1:0] s_i,
  input  logic [QW-1:0]        t_i,
  output logic                 vld_o,
  output logic signed [SW-1:0] s_o,
  output logic [QW-1:0]        t_o
);

  logic                 vld1_r, vld_r;
  logic                 neg_r;
  logic [SW+QW-1:0]     prod_r;
  logic [QW-1:0]        t1_r, t_r;
  logic signed [SW-1:0] s_r, s_nxt;
  logic [SW-1:0]        mag;
  logic [SW+QW:0]       rnd;
  logic signed [SW-1:0] rs;

  always_comb begin
    mag   = s_i[SW-1] ? SW'(-s_i) : SW'(s_i);
    rnd   = ({1'b0, prod_r} + (65'd1 << 29)) >> 30;
    rs    = SW'(rnd);
    s_nxt = COEF + (neg_r ? -rs : rs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld_r  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= s_i[SW-1];
    prod_r <= mag * t_i;
    t1_r   <= t_i;
    s_r    <= s_nxt;
    t_r    <= t1_r;
  end

  assign vld_o = vld_r;
  assign s_o   = s_r;
  assign t_o   = t_r;

endmodule

// ----- hdl/erfc_tay_cell.sv -----
`timescale 1ns / 1ps
module erfc_tay_cell
  import erfc_pkg::*;
#(
  parameter int K = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  exp_ctl_t      ctl_i,
  input  logic [EW-1:0] term_i,
  input  logic [EW-1:0] e_i,
  input  logic [UW-1:0] u_i,
  output exp_ctl_t      ctl_o,
  output logic [EW-1:0] term_o,
  output logic [EW-1:0] e_o,
  output logic [UW-1:0] u_o
);

  localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);
  localparam bit          ODD   = (K % 2) == 1;

  exp_ctl_t      ctl1_r, ctl2_r, ctl_r;
  logic [64:0]   p1_r;
  logic [EW-1:0] e1_r, e2_r, e_r, e_nxt;
  logic [UW-1:0] u1_r, u2_r, u_r;
  logic [31:0]   a, a2_r;
  logic [67:0]   m2_r;
  logic [31:0]   qest, q;
  logic [35:0]   qk, rem;
  logic [EW-1:0] term_r;

  always_comb begin
    a     = p1_r[63:32];
    qest  = 32'(m2_r >> 35);
    qk    = 36'(qest) * 36'(K);
    rem   = {4'b0, a2_r} - qk;
    q     = qest + 32'(rem >= 36'(K));
    e_nxt = ODD ? e2_r - EW'(q) : e2_r + EW'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl_r  <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl_r  <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= term_i * u_i;
    e1_r   <= e_i;
    u1_r   <= u_i;
    a2_r   <= a;
    m2_r   <= a * RECIP;
    e2_r   <= e1_r;
    u2_r   <= u1_r;
    term_r <= EW'(q);
    e_r    <= e_nxt;
    u_r    <= u2_r;
  end

  assign ctl_o  = ctl_r;
  assign term_o = term_r;
  assign e_o    = e_r;
  assign u_o    = u_r;

endmodule

// ----- hdl/erfc_erf_approximation_core.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The 31-cell divider chain and the 12-term exp chain set the depth.
// Reset clears the valid flags and exp control words only; words in flight at reset are dropped.
`include "erfc_erf_approximation_core_assert.svh"
module erfc_erf_approximation_core
  import erfc_pkg::*;
#(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [XW-1:0] in_x_value,
  output logic          busy,
  output logic          out_strobe,
  output logic [OW-1:0] out_erfc_value,
  output logic [OW-1:0] out_erf_value
);

  localparam int DEN_W = (IN_FRAC_BITS < 14) ? 47 - IN_FRAC_BITS : 33;
  localparam int PXW   = 29 + XW;
  localparam logic [PXW:0] PX_HALF = (PXW + 1)'((64'd1 << IN_FRAC_BITS) >> 1);
  localparam int SH    = 2 * IN_FRAC_BITS - 28;
  localparam int SH_R  = (SH > 0) ? SH : 0;
  localparam int SH_L  = (SH < 0) ? -SH : 0;
  localparam logic [44:0] Y_RND = 45'((64'd1 << SH_R) >> 1);
  localparam int OSH   = 32 - OUT_FRAC_BITS;
  localparam logic [35:0] O_RND = (36'd1 << OSH) >> 1;
  localparam logic [35:0] ONE   = 36'd1 << OUT_FRAC_BITS;
  localparam logic [OW-1:0] ONE_M = OW'(ONE);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // front stages
  logic             s1_vld_r, s2_vld_r;
  logic [PXW-1:0]   pxp_r;
  logic [31:0]      sq_r;
  logic [PXW:0]     pxr;
  logic [DEN_W-1:0] den, den_r, rem0_r;
  logic [30:0]      low0_r;
  logic [44:0]      y28w;
  logic [Y28W-1:0]  y28_r;
  logic             fl2_r, fl3_r;

  always_comb begin
    pxr  = ({1'b0, pxp_r} + PX_HALF) >> IN_FRAC_BITS;
    den  = (DEN_W'(1) << 30) + DEN_W'(pxr);
    y28w = (({13'b0, sq_r} + Y_RND) >> SH_R) << SH_L;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pxp_r  <= P_Q30 * in_x_value;
    sq_r   <= in_x_value * in_x_value;
    den_r  <= den;
    rem0_r <= (DEN_W'(1) << 29) + (den >> 32);
    low0_r <= den[31:1];
    y28_r  <= y28w[Y28W-1:0];
    fl2_r  <= |y28w[44:Y28W];
  end

  // divider chain: t = 2^60 / den rounded to nearest, one quotient bit a cell
  logic             dv_vld [DIV_STEPS+1];
  logic [DEN_W-1:0] dv_rem [DIV_STEPS+1];
  logic [DEN_W-1:0] dv_den [DIV_STEPS+1];
  logic [30:0]      dv_low [DIV_STEPS+1];
  logic [QW-1:0]    dv_quo [DIV_STEPS+1];

  assign dv_vld[0] = s2_vld_r;
  assign dv_rem[0] = rem0_r;
  assign dv_den[0] = den_r;
  assign dv_low[0] = low0_r;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    erfc_div_cell #(.DEN_W(DEN_W)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .vld_i(dv_vld[i]),
      .rem_i(dv_rem[i]),
      .den_i(dv_den[i]),
      .low_i(dv_low[i]),
      .quo_i(dv_quo[i]),
      .vld_o(dv_vld[i+1]),
      .rem_o(dv_rem[i+1]),
      .den_o(dv_den[i+1]),
      .low_o(dv_low[i+1]),
      .quo_o(dv_quo[i+1])
    );
  end

  // Horner chain
  localparam logic signed [SW-1:0] HCOEF [5] = '{C_A4, C_A3, C_A2, C_A1, C_ZERO};

  logic                 hr_vld [6];
  logic signed [SW-1:0] hr_s   [6];
  logic [QW-1:0]        hr_t   [6];

  assign hr_vld[0] = dv_vld[DIV_STEPS];
  assign hr_s[0]   = C_A5;
  assign hr_t[0]   = dv_quo[DIV_STEPS];

  for (genvar i = 0; i < 5; i++) begin : g_hrn
    erfc_hrn_cell #(.COEF(HCOEF[i])) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .vld_i(hr_vld[i]),
      .s_i  (hr_s[i]),
      .t_i  (hr_t[i]),
      .vld_o(hr_vld[i+1]),
      .s_o  (hr_s[i+1]),
      .t_o  (hr_t[i+1])
    );
  end

  logic [PW-1:0] poly;
  assign poly = hr_s[5][SW-1] ? '0 : PW'(hr_s[5]);

  // exp(-x*x) front
  logic          s3_vld_r;
  logic [62:0]   zp_r;
  logic [34:0]   z;
  exp_ctl_t      ctl4, ctl4_r, ctl5_r, ctl6_r;
  logic [FW-1:0] f4_r;
  logic [59:0]   up_r;
  logic [UW-1:0] u6_r;

  always_comb begin
    z         = zp_r[62:28];
    ctl4.vld  = s3_vld_r;
    ctl4.n    = z[34:28];
    ctl4.flush = fl3_r || (z[34:28] >= NW'(OUT_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      ctl4_r   <= '0;
      ctl5_r   <= '0;
      ctl6_r   <= '0;
    end else begin
      s3_vld_r <= s2_vld_r;
      ctl4_r   <= ctl4;
      ctl5_r   <= ctl4_r;
      ctl6_r   <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    zp_r  <= y28_r * LOG2E_Q28;
    fl3_r <= fl2_r;
    f4_r  <= z[FW-1:0];
    up_r  <= f4_r * LN2_Q32;
    u6_r  <= up_r[59:28];
  end

  // Taylor chain for exp(-u)
  exp_ctl_t      ty_ctl  [TAYLOR_TERMS+1];
  logic [EW-1:0] ty_term [TAYLOR_TERMS+1];
  logic [EW-1:0] ty_e    [TAYLOR_TERMS+1];
  logic [UW-1:0] ty_u    [TAYLOR_TERMS+1];

  assign ty_ctl[0]  = ctl6_r;
  assign ty_term[0] = EW'(1) << 32;
  assign ty_e[0]    = EW'(1) << 32;
  assign ty_u[0]    = u6_r;

  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_tay
    erfc_tay_cell #(.K(i + 1)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ty_ctl[i]),
      .term_i(ty_term[i]),
      .e_i   (ty_e[i]),
      .u_i   (ty_u[i]),
      .ctl_o (ty_ctl[i+1]),
      .term_o(ty_term[i+1]),
      .e_o   (ty_e[i+1]),
      .u_o   (ty_u[i+1])
    );
  end

  // scale by 2^-n, then join with the polynomial
  exp_ctl_t      ctl_t;
  logic [EW:0]   esum;
  logic          ex_vld_r, mul_vld_r, out_strobe_r;
  logic [EW-1:0] ex_r;
  logic [64:0]   prod8_r;
  logic [35:0]   r32, erfc_full, erfc_c, erf_c;
  logic [OW-1:0] erfc_r, erf_r;

  always_comb begin
    ctl_t     = ty_ctl[TAYLOR_TERMS];
    esum      = ({1'b0, ty_e[TAYLOR_TERMS]} + (((EW + 1)'(1) << ctl_t.n) >> 1)) >> ctl_t.n;
    r32       = 36'(prod8_r[64:30]);
    erfc_full = (r32 + O_RND) >> OSH;
    erfc_c    = (erfc_full > ONE) ? ONE : erfc_full;
    erf_c     = ONE - erfc_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r     <= 1'b0;
      mul_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      ex_vld_r     <= ctl_t.vld;
      mul_vld_r    <= hr_vld[5];
      out_strobe_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_r    <= ctl_t.flush ? '0 : esum[EW-1:0];
    prod8_r <= poly * ex_r;
    erfc_r  <= erfc_c[OW-1:0];
    erf_r   <= erf_c[OW-1:0];
  end

  assign out_strobe     = out_strobe_r;
  assign out_erfc_value = erfc_r;
  assign out_erf_value  = erf_r;

  `ERFC_ASSERT(a_paths_aligned, hr_vld[5] == ex_vld_r, "polynomial and exp paths out of step")
  `ERFC_ASSERT(a_strobe_follows, out_strobe |-> $past(mul_vld_r), "strobe without a product")
  `ERFC_ASSERT(a_sum_one, out_strobe |-> (out_erfc_value + out_erf_value) == ONE_M, "erf and erfc do not sum to one")
  `ERFC_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_strobe, "strobe after reset")

endmodule

// ----- bench/erfc_checker.sv -----
`timescale 1ns / 1ps
module erfc_checker
  import erfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic [XW-1:0] in_x_value,
  input  logic          out_strobe,
  input  logic [OW-1:0] out_erfc_value,
  input  logic [OW-1:0] out_erf_value,
  output int            fail_count,
  output int            pending_count
);

  localparam int IFB = IN_FRAC_BITS_DEF;
  localparam int OFB = OUT_FRAC_BITS_DEF;

  typedef struct packed {
    logic [OW-1:0] erfc_v;
    logic [OW-1:0] erf_v;
  } erfc_pair_t;

  erfc_pair_t pair_q[$];
  int mismatches = 0;

  assign fail_count    = mismatches;
  assign pending_count = pair_q.size();

  function automatic longint signed q30_mul(longint signed s, longint unsigned t);
    logic           neg;
    longint unsigned m;
    longint unsigned r;
    neg = s < 0;
    m = neg ? longint'(-s) : longint'(s);
    r = (m * t + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned gauss_q32(longint unsigned x);
    longint unsigned y, y28, z, n, u, e, term;
    int sh;
    y = x * x;
    sh = 2 * IFB - 28;
    if (sh > 0) y28 = (y + (64'd1 << (sh - 1))) >> sh;
    else y28 = y << (-sh);
    if (y28 >= (64'd64 << 28)) return 0;
    z = (y28 * L2E_Q28) >> 28;
    n = z >> 28;
    if (n >= OFB) return 0;
    u = ((z & ((64'd1 << 28) - 1)) * LN2_Q32_W) >> 28;
    e = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * u) >> 32) / k;
      if (k % 2 == 1) e = e - term;
      else e = e + term;
    end
    if (n > 0) e = (e + (64'd1 << (n - 1))) >> n;
    return e;
  endfunction

  function automatic erfc_pair_t erfc_of(logic [XW-1:0] xv);
    longint unsigned x, px, den, t, poly, ex, r32, one, ev;
    longint signed s;
    erfc_pair_t p;
    x = xv;
    px = (PX_Q30 * x + (64'd1 << (IFB - 1))) >> IFB;
    den = (64'd1 << 30) + px;
    t = ((64'd1 << 60) + den / 2) / den;
    s = A5_Q30;
    s = -longint'(A4_Q30) + q30_mul(s, t);
    s = longint'(A3_Q30) + q30_mul(s, t);
    s = -longint'(A2_Q30) + q30_mul(s, t);
    s = longint'(A1_Q30) + q30_mul(s, t);
    s = q30_mul(s, t);
    poly = s < 0 ? 0 : s;
    ex = gauss_q32(x);
    r32 = (poly * ex) >> 30;
    ev = (r32 + (64'd1 << (31 - OFB))) >> (32 - OFB);
    one = 64'd1 << OFB;
    if (ev > one) ev = one;
    p.erfc_v = OW'(ev);
    p.erf_v  = OW'(one - ev);
    return p;
  endfunction

  always @(posedge clk) begin
    erfc_pair_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pair_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected word: erfc %0d erf %0d", out_erfc_value, out_erf_value);
        end else begin
          want = pair_q.pop_front();
          if (want.erfc_v !== out_erfc_value || want.erf_v !== out_erf_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: erfc exp %0d got %0d, erf exp %0d got %0d",
                       want.erfc_v, out_erfc_value, want.erf_v, out_erf_value);
          end
        end
      end
      if (start && !busy) pair_q.push_back(erfc_of(in_x_value));
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import erfc_pkg::*;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 2000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [XW-1:0] in_x_value = '0;
  logic          busy;
  logic          out_strobe;
  logic [OW-1:0] out_erfc_value;
  logic [OW-1:0] out_erf_value;
  int            fail_count;
  int            pending_count;
  int            idle_cycles = 0;

  logic [XW-1:0] directed_x [23] = '{16'h0000, 16'h0001, 16'h0002, 16'h0800, 16'h1000,
    16'h1800, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'h5a00, 16'h6000, 16'h7000,
    16'h7fff, 16'h8000, 16'haaaa, 16'h5555, 16'hffff, 16'hfffe, 16'h4a00, 16'h4b00,
    16'h0400, 16'h0c00};

  always #5 clk = ~clk;

  erfc_erf_approximation_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_x_value(in_x_value), .busy(busy),
    .out_strobe(out_strobe), .out_erfc_value(out_erfc_value), .out_erf_value(out_erf_value)
  );

  erfc_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_x_value(in_x_value),
    .out_strobe(out_strobe), .out_erfc_value(out_erfc_value),
    .out_erf_value(out_erf_value), .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_word(logic [XW-1:0] xv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 1) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_x_value <= xv;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random();
    logic [XW-1:0] xv;
    case ($urandom_range(0, 3))
      0: xv = XW'($urandom_range(0, 16'h6000));
      1: xv = XW'($urandom_range(0, 16'h1000));
      default: xv = XW'($urandom);
    endcase
    send_word(xv);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_x[i]) send_word(directed_x[i]);
    repeat (750) send_random();
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
